FILE: hdl/cdq_pkg.sv
// ============================================================================
// cdq_pkg: shared types and constants for the circular deque engine
// Holds the storage depth, the request and status codes, and the packed
// words that travel on the command, result and cell control paths.
// ============================================================================
`default_nettype none

package cdq_pkg;

    localparam int DEPTH       = 8;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int OUT_CNT_W   = 4;

    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic [1:0] req_type;
        data_t      item_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        data_t                popped_value;
        logic [OUT_CNT_W-1:0] entry_count;
        logic                 is_empty;
        data_t                front_value;
        data_t                rear_value;
    } result_t;

    // one-hot per request; only raised when the request is legal
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/cdq_cell.sv
// ============================================================================
// cdq_cell: one slot of the deque chain
// Holds one word and its occupied flag; shifts toward either neighbor,
// loads at the rear boundary, and drops out when it is the last occupied slot.
// ============================================================================
`default_nettype none

module cdq_cell (
    input  wire                clk,
    input  wire                rst_n,
    input  cdq_pkg::cell_ctl_t ctl,
    input  cdq_pkg::data_t     item,
    input  cdq_pkg::data_t     left_data,
    input  wire                left_valid,
    input  cdq_pkg::data_t     right_data,
    input  wire                right_valid,
    output cdq_pkg::data_t     data,
    output logic               valid,
    output cdq_pkg::data_t     tap
);

    cdq_pkg::data_t data_reg, data_next;
    logic           valid_reg, valid_next;
    logic           is_rear;

    assign is_rear = valid_reg && !right_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctl.push_front)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctl.push_rear)
        begin
            // first free slot after the occupied run
            if (!valid_reg && left_valid)
            begin
                data_next  = item;
                valid_next = 1'b1;
            end
        end
        else if (ctl.pop_front)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctl.pop_rear)
        begin
            if (is_rear)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign tap   = is_rear ? data_reg : '0;

endmodule

`default_nettype wire

FILE: hdl/circular_deque_engine.sv
// ============================================================================
// circular_deque_engine: double-ended queue of signed 32-bit words
// A row of DEPTH cells keeps the deque packed from cell 0 (front) onward.
// ============================================================================
//
// Usage:
//   Command channel: drive cmd and raise start; a word is taken at every
//   rising edge with start high and busy low. busy is always low, so one
//   request can be taken in every cycle.
//   Result channel: done is high for exactly one cycle, the cycle after the
//   request was taken; result is valid only in that cycle and must be
//   captured then, since the receiver has no way to stall it.
//   Throughput is one request per cycle: each request is a single shift or
//   load step across the cell row.
//   Push front shifts every cell one place toward the rear; push rear loads
//   the first free cell; pop front shifts toward the front; pop rear clears
//   the last occupied cell. Full pushes report overflow, empty pops report
//   underflow, and neither changes the contents.
//   Reset clears the occupied flags and the count; the deque starts empty.
//   front_value and rear_value are read from the cells in the done cycle,
//   so they show the state right after the request.
// ============================================================================
`default_nettype none

module circular_deque_engine (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    input  cdq_pkg::cmd_t    cmd,
    output logic             done,
    output cdq_pkg::result_t result
);

    localparam int N = cdq_pkg::DEPTH;

    cdq_pkg::cell_ctl_t            ctl;
    cdq_pkg::data_t                cell_data  [N];
    logic                          cell_valid [N];
    cdq_pkg::data_t                cell_tap   [N];
    cdq_pkg::data_t                rear_word;

    logic [cdq_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          done_reg;
    logic [1:0]                    status_reg, status_next;
    cdq_pkg::data_t                popped_reg, popped_next;

    logic                          is_push, is_full, is_empty_now, accept;

    assign busy         = 1'b0;
    assign accept       = start && !busy;
    assign is_push      = (cmd.req_type == cdq_pkg::REQ_PUSH_FRONT) ||
                          (cmd.req_type == cdq_pkg::REQ_PUSH_REAR);
    assign is_full      = (count_reg == cdq_pkg::CNT_W'(N));
    assign is_empty_now = (count_reg == '0);

    // rear word: the single occupied cell whose neighbor is free
    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < N; i++)
        begin
            rear_word = rear_word | cell_tap[i];
        end
    end

    // request decode, status and popped word
    always_comb
    begin
        ctl         = '0;
        status_next = cdq_pkg::ST_DONE;
        popped_next = '0;
        count_next  = count_reg;
        if (accept)
        begin
            if (is_push && is_full)
            begin
                status_next = cdq_pkg::ST_OVERFLOW;
            end
            else if (!is_push && is_empty_now)
            begin
                status_next = cdq_pkg::ST_UNDERFLOW;
            end
            else
            begin
                case (cmd.req_type)
                    cdq_pkg::REQ_PUSH_FRONT:
                    begin
                        ctl.push_front = 1'b1;
                        count_next     = count_reg + cdq_pkg::CNT_W'(1);
                    end
                    cdq_pkg::REQ_PUSH_REAR:
                    begin
                        ctl.push_rear = 1'b1;
                        count_next    = count_reg + cdq_pkg::CNT_W'(1);
                    end
                    cdq_pkg::REQ_POP_FRONT:
                    begin
                        ctl.pop_front = 1'b1;
                        popped_next   = cell_data[0];
                        count_next    = count_reg - cdq_pkg::CNT_W'(1);
                    end
                    cdq_pkg::REQ_POP_REAR:
                    begin
                        ctl.pop_rear = 1'b1;
                        popped_next  = rear_word;
                        count_next   = count_reg - cdq_pkg::CNT_W'(1);
                    end
                    default:
                    begin
                        ctl = '0;
                    end
                endcase
            end
        end
    end

    // the cell row
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        cdq_pkg::data_t l_data, r_data;
        logic           l_valid, r_valid;

        if (g == 0)
        begin : g_first
            assign l_data  = cmd.item_value;
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data  = cell_data[g-1];
            assign l_valid = cell_valid[g-1];
        end

        if (g == N - 1)
        begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data  = cell_data[g+1];
            assign r_valid = cell_valid[g+1];
        end

        cdq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .item        (cmd.item_value),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[g]),
            .valid       (cell_valid[g]),
            .tap         (cell_tap[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    assign done                = done_reg;
    assign result.status       = status_reg;
    assign result.popped_value = popped_reg;
    assign result.entry_count  = cdq_pkg::OUT_CNT_W'(count_reg);
    assign result.is_empty     = is_empty_now;
    assign result.front_value  = is_empty_now ? '0 : cell_data[0];
    assign result.rear_value   = is_empty_now ? '0 : rear_word;

endmodule

`default_nettype wire

FILE: hdl/cdq_checker.sv
// ============================================================================
// cdq_checker: port-level checks for the circular deque engine
// Watches the command and result ports and flags inconsistent results.
// ============================================================================
`default_nettype none

module cdq_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              start,
    input wire              busy,
    input wire              done,
    input cdq_pkg::result_t result
);

    // every taken request yields exactly one result, in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("taken request produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without a request");

    a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |->
            (result.entry_count == '0) && (result.front_value == '0) &&
            (result.rear_value == '0))
        else $error("empty deque shows data or a count");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == cdq_pkg::ST_UNDERFLOW) |->
            result.is_empty && (result.popped_value == '0))
        else $error("underflow with data present");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == cdq_pkg::ST_OVERFLOW) |->
            (result.entry_count == cdq_pkg::OUT_CNT_W'(cdq_pkg::DEPTH)))
        else $error("overflow while not full");

endmodule

bind circular_deque_engine cdq_checker u_cdq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
